[rtl/core/pfxa_pkg.sv]
// pfxa_pkg: types, op codes and command structs for the fixed-point alu
// no dependencies
`default_nettype none
package pfxa_pkg;

    localparam int unsigned XLEN = 64;
    localparam int unsigned IMM_W = 16;
    localparam int unsigned HALF = 32;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_ADDE = 6'd2, OP_ADDI = 6'd3,
        OP_ADDIC = 6'd4, OP_ADDIC_R = 6'd5, OP_ADDIS = 6'd6, OP_ADDME = 6'd7,
        OP_ADDZE = 6'd8, OP_AND = 6'd9, OP_ANDC = 6'd10, OP_ANDI = 6'd11,
        OP_ANDIS = 6'd12, OP_CNTLZD = 6'd13, OP_CNTLZW = 6'd14, OP_DIVD = 6'd15,
        OP_DIVDU = 6'd16, OP_DIVW = 6'd17, OP_DIVWU = 6'd18, OP_EQV = 6'd19,
        OP_EXTSB = 6'd20, OP_EXTSH = 6'd21, OP_EXTSW = 6'd22, OP_MULHD = 6'd23,
        OP_MULHDU = 6'd24, OP_MULHW = 6'd25, OP_MULHWU = 6'd26, OP_MULLD = 6'd27,
        OP_MULLI = 6'd28, OP_MULLW = 6'd29, OP_NAND = 6'd30, OP_NEG = 6'd31,
        OP_NOR = 6'd32, OP_OR = 6'd33, OP_ORC = 6'd34, OP_ORI = 6'd35,
        OP_ORIS = 6'd36, OP_SUBF = 6'd37, OP_SUBFC = 6'd38, OP_SUBFE = 6'd39,
        OP_SUBFIC = 6'd40, OP_SUBFME = 6'd41, OP_SUBFZE = 6'd42, OP_XOR = 6'd43,
        OP_XORI = 6'd44, OP_XORIS = 6'd45
    } op_t;

    localparam logic [1:0] CR_NEG = 2'd0;
    localparam logic [1:0] CR_POS = 2'd1;
    localparam logic [1:0] CR_ZERO = 2'd2;

    typedef struct packed {
        logic [5:0]       op;
        logic [XLEN-1:0]  first_operand;
        logic [XLEN-1:0]  second_operand;
        logic [IMM_W-1:0] immediate;
        logic             ra_is_zero;
        logic             overflow_enable;
        logic             record_enable;
    } in_item_t;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            write_enable;
        logic            cr0_valid;
        logic [1:0]      cr0_code;
        logic            carry_out;
        logic            overflow_out;
        logic            summary_overflow_out;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic mul_done;
        logic div_done;
    } status_t;

endpackage
`default_nettype wire

[rtl/core/pfxa_ctrl.sv]
// pfxa_ctrl: sequencer for load, multiply, divide, finish and output hold
// depends on pfxa_pkg
`default_nettype none
module pfxa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pfxa_pkg::cmd_t       cmd,
    input  wire pfxa_pkg::status_t sts
);
    import pfxa_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FIN;
                if (in_valid && sts.is_mul)
                    state_next = ST_MUL;
                if (in_valid && sts.is_div)
                    state_next = ST_DIV;
            end
            ST_MUL:  if (sts.mul_done) state_next = ST_FIN;
            ST_DIV:  if (sts.div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:  cmd.mul_step = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_FIN:  cmd.finish = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/pfxa_dp.sv]
// pfxa_dp: operand registers, adder, logic, 32x32 partial-product multiplier, radix-2 divider, xer flags
// depends on pfxa_pkg
`default_nettype none
module pfxa_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pfxa_pkg::in_item_t in_item,
    input  wire pfxa_pkg::cmd_t     cmd,
    output pfxa_pkg::status_t       sts,
    output pfxa_pkg::out_item_t     out_item
);
    import pfxa_pkg::*;

    in_item_t        item_reg;
    logic [XLEN-1:0] ma_reg, mb_reg;          // unsigned multiplier operands
    logic [2*XLEN-1:0] prod_reg;
    logic [1:0]      mcnt_reg;
    logic [XLEN-1:0] dq_reg, drem_reg, dd_reg;
    logic [6:0]      dcnt_reg;
    logic            neg_reg;                // product or quotient is negated
    logic            rneg_dummy;
    logic            ca_reg, ov_reg, so_reg;
    out_item_t       out_reg;

    op_t op_in, op;
    assign op_in = op_t'(in_item.op);
    assign op = op_t'(item_reg.op);

    logic [XLEN-1:0] a_in, b_in, simm_in;
    assign a_in = in_item.first_operand;
    assign b_in = in_item.second_operand;
    assign simm_in = {{(XLEN-IMM_W){in_item.immediate[IMM_W-1]}}, in_item.immediate};

    // classify incoming op
    logic in_mul, in_div, in_word, in_signed;
    always_comb
    begin
        in_mul = 1'b0; in_div = 1'b0; in_word = 1'b0; in_signed = 1'b0;
        case (op_in)
            OP_MULHD, OP_MULLD, OP_MULLI: begin in_mul = 1'b1; in_signed = 1'b1; end
            OP_MULHDU:                    in_mul = 1'b1;
            OP_MULHW, OP_MULLW: begin in_mul = 1'b1; in_signed = 1'b1; in_word = 1'b1; end
            OP_MULHWU:          begin in_mul = 1'b1; in_word = 1'b1; end
            OP_DIVD:            begin in_div = 1'b1; in_signed = 1'b1; end
            OP_DIVDU:           in_div = 1'b1;
            OP_DIVW:            begin in_div = 1'b1; in_signed = 1'b1; in_word = 1'b1; end
            OP_DIVWU:           begin in_div = 1'b1; in_word = 1'b1; end
            default: ;
        endcase
    end

    // operand preparation: magnitudes for the shared units
    logic [XLEN-1:0] opa, opb, maga, magb, min_val;
    logic div_bad;
    always_comb
    begin
        opa = a_in;
        opb = (op_in == OP_MULLI) ? simm_in : b_in;
        if (in_word)
        begin
            opa = in_signed ? {{HALF{a_in[HALF-1]}}, a_in[HALF-1:0]}
                            : {{HALF{1'b0}}, a_in[HALF-1:0]};
            opb = in_signed ? {{HALF{b_in[HALF-1]}}, b_in[HALF-1:0]}
                            : {{HALF{1'b0}}, b_in[HALF-1:0]};
        end
        maga = (in_signed && opa[XLEN-1]) ? (~opa + 1'b1) : opa;
        magb = (in_signed && opb[XLEN-1]) ? (~opb + 1'b1) : opb;
        // most negative dividend of the operand width, sign-extended
        min_val = in_word ? {{(HALF+1){1'b1}}, {(HALF-1){1'b0}}}
                          : {1'b1, {(XLEN-1){1'b0}}};
        div_bad = (opb == '0) ||
                  (in_signed && opa == min_val && opb == '1);
    end

    // partial product: one 32x32 quarter per step
    logic [HALF-1:0] pa, pb;
    logic [2*HALF-1:0] pp;
    logic [2*XLEN-1:0] pp_sh;
    always_comb
    begin
        pa = mcnt_reg[0] ? ma_reg[XLEN-1:HALF] : ma_reg[HALF-1:0];
        pb = mcnt_reg[1] ? mb_reg[XLEN-1:HALF] : mb_reg[HALF-1:0];
        pp = pa * pb;
        pp_sh = {{XLEN{1'b0}}, pp} << (HALF * (32'(mcnt_reg[0]) + 32'(mcnt_reg[1])));
    end

    // restoring divide step
    logic [XLEN:0] trial;
    logic [XLEN-1:0] rem_sh;
    assign rem_sh = {drem_reg[XLEN-2:0], dq_reg[XLEN-1]};
    assign trial = {drem_reg[XLEN-1], rem_sh} - {1'b0, dd_reg};

    assign sts.is_mul = in_mul;
    assign sts.is_div = in_div && !div_bad;
    assign sts.mul_done = (mcnt_reg == 2'd3);
    assign sts.div_done = (dcnt_reg == 7'(XLEN-1));

    // unit registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            ma_reg <= maga;
            mb_reg <= magb;
            prod_reg <= '0;
            mcnt_reg <= '0;
            dq_reg <= maga;
            drem_reg <= '0;
            dd_reg <= magb;
            dcnt_reg <= '0;
            neg_reg <= in_signed && (opa[XLEN-1] ^ opb[XLEN-1]);
            rneg_dummy <= div_bad;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_reg + pp_sh;
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (cmd.div_step)
        begin
            if (!trial[XLEN])
            begin
                drem_reg <= trial[XLEN-1:0];
                dq_reg <= {dq_reg[XLEN-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_sh;
                dq_reg <= {dq_reg[XLEN-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 7'd1;
        end
    end

    // final result computation from registered item
    logic [XLEN-1:0] a, b, imm, simm, sum_a, sum_b, d, lz_src;
    logic [2*XLEN-1:0] sprod;
    logic [XLEN-1:0] squot;
    logic [XLEN:0] sum;
    logic cin, we, rec, use_oe, set_ca, ov, cy, add_op;
    logic [6:0] lz;
    always_comb
    begin
        a = item_reg.first_operand;
        b = item_reg.second_operand;
        imm = {{(XLEN-IMM_W){1'b0}}, item_reg.immediate};
        simm = {{(XLEN-IMM_W){item_reg.immediate[IMM_W-1]}}, item_reg.immediate};
        sprod = neg_reg ? (~prod_reg + 1'b1) : prod_reg;
        squot = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
        sum_a = a; sum_b = b; cin = 1'b0; add_op = 1'b0;
        d = '0; we = 1'b1; rec = item_reg.record_enable; use_oe = 1'b0;
        set_ca = 1'b0; ov = 1'b0;
        case (op)
            OP_ADD:    begin add_op = 1'b1; use_oe = 1'b1; end
            OP_ADDC:   begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1; end
            OP_ADDE:   begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1; cin = ca_reg; end
            OP_ADDI:   begin add_op = 1'b1; rec = 1'b0;
                             sum_a = item_reg.ra_is_zero ? '0 : a; sum_b = simm; end
            OP_ADDIC:  begin add_op = 1'b1; rec = 1'b0; set_ca = 1'b1; sum_b = simm; end
            OP_ADDIC_R:begin add_op = 1'b1; rec = 1'b1; set_ca = 1'b1; sum_b = simm; end
            OP_ADDIS:  begin add_op = 1'b1; rec = 1'b0;
                             sum_a = item_reg.ra_is_zero ? '0 : a;
                             sum_b = {simm[XLEN-IMM_W-1:0], {IMM_W{1'b0}}}; end
            OP_ADDME:  begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_b = '1; cin = ca_reg; end
            OP_ADDZE:  begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_b = '0; cin = ca_reg; end
            OP_SUBF:   begin add_op = 1'b1; use_oe = 1'b1; sum_a = ~a; cin = 1'b1; end
            OP_SUBFC:  begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_a = ~a; cin = 1'b1; end
            OP_SUBFE:  begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_a = ~a; cin = ca_reg; end
            OP_SUBFIC: begin add_op = 1'b1; rec = 1'b0; set_ca = 1'b1;
                             sum_a = ~a; sum_b = simm; cin = 1'b1; end
            OP_SUBFME: begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_a = ~a; sum_b = '1; cin = ca_reg; end
            OP_SUBFZE: begin add_op = 1'b1; use_oe = 1'b1; set_ca = 1'b1;
                             sum_a = ~a; sum_b = '0; cin = ca_reg; end
            OP_NEG:    begin add_op = 1'b1; use_oe = 1'b1;
                             sum_a = ~a; sum_b = '0; cin = 1'b1; end
            default: ;
        endcase
        sum = {1'b0, sum_a} + {1'b0, sum_b} + {{XLEN{1'b0}}, cin};
        cy = sum[XLEN];
        if (add_op)
        begin
            d = sum[XLEN-1:0];
            ov = (sum_a[XLEN-1] == sum_b[XLEN-1]) && (d[XLEN-1] != sum_a[XLEN-1]);
            if (op == OP_NEG)
                ov = (a == {1'b1, {(XLEN-1){1'b0}}});
        end
        lz_src = (op == OP_CNTLZW) ? {a[HALF-1:0], {HALF{1'b1}}} : a;
        lz = 7'(XLEN);
        for (int i = 0; i < XLEN; i++)
            if (lz_src[i])
                lz = 7'(XLEN - 1 - i);
        case (op)
            OP_AND:    d = a & b;
            OP_ANDC:   d = a & ~b;
            OP_ANDI:   begin d = a & imm; rec = 1'b1; end
            OP_ANDIS:  begin d = a & (imm << IMM_W); rec = 1'b1; end
            OP_CNTLZD: d = {{(XLEN-7){1'b0}}, lz};
            OP_CNTLZW: d = {{(XLEN-7){1'b0}}, lz};
            OP_EQV:    d = ~(a ^ b);
            OP_EXTSB:  d = {{(XLEN-8){a[7]}}, a[7:0]};
            OP_EXTSH:  d = {{(XLEN-16){a[15]}}, a[15:0]};
            OP_EXTSW:  d = {{HALF{a[HALF-1]}}, a[HALF-1:0]};
            OP_NAND:   d = ~(a & b);
            OP_NOR:    d = ~(a | b);
            OP_OR:     d = a | b;
            OP_ORC:    d = a | ~b;
            OP_ORI:    begin d = a | imm; rec = 1'b0; end
            OP_ORIS:   begin d = a | (imm << IMM_W); rec = 1'b0; end
            OP_XOR:    d = a ^ b;
            OP_XORI:   begin d = a ^ imm; rec = 1'b0; end
            OP_XORIS:  begin d = a ^ (imm << IMM_W); rec = 1'b0; end
            OP_MULHD, OP_MULHDU: d = sprod[2*XLEN-1:XLEN];
            OP_MULHW:  d = {{HALF{sprod[2*HALF-1]}}, sprod[2*HALF-1:HALF]};
            OP_MULHWU: d = {{HALF{1'b0}}, sprod[2*HALF-1:HALF]};
            OP_MULLD:  begin d = sprod[XLEN-1:0]; use_oe = 1'b1;
                             ov = (sprod[2*XLEN-1:XLEN] != {XLEN{sprod[XLEN-1]}}); end
            OP_MULLI:  begin d = sprod[XLEN-1:0]; rec = 1'b0; end
            OP_MULLW:  begin d = sprod[XLEN-1:0]; use_oe = 1'b1;
                             ov = (d[XLEN-1:HALF-1] != {(HALF+1){d[HALF-1]}}); end
            OP_DIVD, OP_DIVDU, OP_DIVW, OP_DIVWU:
            begin
                use_oe = 1'b1;
                ov = rneg_dummy;
                we = !rneg_dummy;
                rec = item_reg.record_enable && !rneg_dummy;
                if (op == OP_DIVW)
                    d = {{HALF{squot[HALF-1]}}, squot[HALF-1:0]};
                else
                    d = squot;
                if (rneg_dummy)
                    d = '0;
            end
            default:
                if (!add_op)
                begin
                    we = 1'b0; rec = 1'b0; d = '0;
                end
        endcase
        use_oe = use_oe && item_reg.overflow_enable;
    end

    // xer flags and output register
    logic ca_next, ov_next, so_next;
    always_comb
    begin
        ca_next = set_ca ? cy : ca_reg;
        ov_next = use_oe ? ov : ov_reg;
        so_next = so_reg | (use_oe & ov);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= 1'b0;
            ov_reg <= 1'b0;
            so_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            ca_reg <= ca_next;
            ov_reg <= ov_next;
            so_reg <= so_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.result <= d;
            out_reg.write_enable <= we;
            out_reg.cr0_valid <= rec;
            out_reg.cr0_code <= !rec ? CR_NEG : (d == '0) ? CR_ZERO :
                                d[XLEN-1] ? CR_NEG : CR_POS;
            out_reg.carry_out <= ca_next;
            out_reg.overflow_out <= ov_next;
            out_reg.summary_overflow_out <= so_next;
        end
    end

    assign out_item = out_reg;

endmodule
`default_nettype wire

[rtl/core/ppc_fixed_point_alu_top.sv]
// ppc_fixed_point_alu_top: 64-bit fixed-point alu, controller plus datapath
// depends on pfxa_pkg, pfxa_ctrl, pfxa_dp
//
//   channel  | signals                        | item
//   input    | in_valid, in_ready, in_item    | pfxa_pkg::in_item_t
//   output   | out_valid, out_ready, out_item | pfxa_pkg::out_item_t
//
// simple ops: the finish state follows accept, then the result is valid in the output state
// multiplies pass through the multiply state: one 32x32 partial product per cycle
// divides pass through the divide state: one radix-2 restoring step per cycle
// divide by zero or divide overflow skips the divide steps
// one item in flight; in_ready stays low until the result is taken
// rst_n clears the sequencer and the xer bits ca, ov, so
`default_nettype none
module ppc_fixed_point_alu_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pfxa_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pfxa_pkg::out_item_t      out_item
);
    import pfxa_pkg::*;

    cmd_t    cmd;
    status_t sts;

    pfxa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    pfxa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
        .out_item(out_item)
    );

endmodule
`default_nettype wire
